@@ rtl/toti_pkg.sv @@
// Package: shared types and constants of the two-opt tour improver.
`default_nettype none
package toti_pkg;
  localparam int MaxCities = 64;
  localparam int CityW = $clog2(MaxCities);
  localparam int DistW = 16;
  localparam int LenW = 22;
  localparam int DAddrW = 2 * CityW;

  localparam logic [1:0] ModeDist = 2'd0;
  localparam logic [1:0] ModeTour = 2'd1;
  localparam logic [1:0] ModeRun = 2'd2;

  localparam logic [1:0] CfgCityCount = 2'd0;
  localparam logic [1:0] CfgPassLimit = 2'd1;

  typedef struct packed {
    logic [1:0] mode;
    logic [CityW-1:0] from_city;
    logic [CityW-1:0] to_city;
    logic [DistW-1:0] distance;
    logic [CityW-1:0] tour_position;
    logic [CityW-1:0] tour_city;
  } in_item_t;

  typedef struct packed {
    logic [CityW-1:0] position;
    logic [CityW-1:0] city;
    logic [LenW-1:0] tour_length;
    logic last;
  } out_item_t;
endpackage
`default_nettype wire

@@ rtl/toti_dist_ram.sv @@
// Distance matrix memory: one write port, one registered read port.
`default_nettype none
module toti_dist_ram
  import toti_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [DAddrW-1:0] waddr_i,
  input  wire logic [DistW-1:0]  wdata_i,
  input  wire logic [DAddrW-1:0] raddr_i,
  output logic      [DistW-1:0]  rdata_o
);
  logic [DistW-1:0] mem [2**DAddrW];
  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    rdata_o <= mem[raddr_i];
  end
endmodule
`default_nettype wire

@@ rtl/two_opt_tour_improver.sv @@
// Top level: loads a distance matrix and tour, runs 2-opt passes, emits the tour.
//
// Input channel (in_valid_i/in_ready_o/in_data_i): mode 0 writes a distance
// entry, mode 1 a tour position, mode 2 starts a run; mode 3 is dropped.
// in_ready_o is high only while the controller is idle; write items are then
// taken one per cycle. A run starts from idle; each pass does its bookkeeping
// and then, per candidate move, two tour read pairs, four reads of the single
// distance port and one compare; a reversal adds a read and a write step per
// swapped pair. Passes stop after a pass without a reversal or at pass_limit.
// The length then takes a tour read, a distance read and an add per position,
// and result transactions follow, one per position in order, last on N-1,
// each read from the tour store before it is registered, while the receiver is ready.
// Configuration writes (cfg_*) are taken only while idle; index 0 sets the
// city count (clamped to 4..64), index 1 the pass limit.
// Reset clears the controller to idle, empties the output register and sets
// the registers to 64 and 19; the stores are undefined until written.
// A stalled receiver holds the output register and the sequencer waits; no
// input is taken until the last result transaction of a run is registered.
`default_nettype none
module two_opt_tour_improver
  import toti_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire in_item_t   in_data_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output out_item_t       out_data_o,
  input  wire logic       cfg_valid_i,
  output logic            cfg_ready_o,
  input  wire logic [1:0] cfg_index_i,
  input  wire logic [7:0] cfg_data_i
);
  localparam logic [4:0] SIdle = 5'd0, SPass = 5'd1, SNext = 5'd2, SRdT = 5'd3,
    SRdT2 = 5'd4, SD0 = 5'd5, SD1 = 5'd6, SD2 = 5'd7, SD3 = 5'd8, SCmp = 5'd9,
    SRevRd = 5'd10, SRev = 5'd11, SLen = 5'd12, SLenW = 5'd13, SLenA = 5'd14,
    SEmit = 5'd15, SEmitW = 5'd16;

  logic [4:0] st_q;
  logic [6:0] cnt_q;
  logic [7:0] lim_q, pass_q;
  logic swap_q;
  logic [CityW-1:0] i_q, j_q, lo_q, hi_q, k_q;
  logic [CityW-1:0] c_a_q, c_b_q, c_c_q, c_d_q; // p[i-1], p[i], p[j], p[j+1]
  logic [DistW:0] gain_q, cost_q;
  logic [LenW-1:0] len_q;
  logic ob_full_q;
  logic [CityW-1:0] tour [MaxCities];
  logic [CityW-1:0] t_ra, t_rb, t_a_q, t_b_q;
  logic [DAddrW-1:0] d_ra;
  logic [DistW-1:0] d_q;
  logic [CityW-1:0] n1;
  logic [6:0] n_eff;
  logic in_acc, out_load, better, j_end;
  logic t_we, t_we2;
  logic [CityW-1:0] t_wa, t_wd, t_wa2, t_wd2;

  assign n_eff = (cnt_q < 7'd4) ? 7'd4 :
                 ((cnt_q > 7'(MaxCities)) ? 7'(MaxCities) : cnt_q);
  assign n1 = CityW'(n_eff - 7'd1);
  assign in_ready_o = (st_q == SIdle);
  assign cfg_ready_o = (st_q == SIdle);
  assign in_acc = in_valid_i && in_ready_o;
  assign out_valid_o = ob_full_q;
  assign out_load = (st_q == SEmitW) && (!ob_full_q || out_ready_i);
  assign better = (gain_q < cost_q + {1'b0, d_q});
  assign j_end = (7'(j_q) + 7'd2 >= n_eff);

  toti_dist_ram u_dist (
    .clk_i, .we_i(in_acc && in_data_i.mode == ModeDist),
    .waddr_i({in_data_i.from_city, in_data_i.to_city}),
    .wdata_i(in_data_i.distance), .raddr_i(d_ra), .rdata_o(d_q));

  // tour memory: two registered reads, two writes per cycle (swap uses read data)
  always_ff @(posedge clk_i) begin
    if (t_we) tour[t_wa] <= t_wd;
    if (t_we2) tour[t_wa2] <= t_wd2;
    t_a_q <= tour[t_ra];
    t_b_q <= tour[t_rb];
  end

  always_comb begin
    t_ra = lo_q; t_rb = hi_q;
    d_ra = {c_a_q, c_b_q};
    t_we = 1'b0; t_wa = in_data_i.tour_position; t_wd = in_data_i.tour_city;
    t_we2 = 1'b0; t_wa2 = hi_q; t_wd2 = t_a_q;
    unique case (st_q)
      SIdle: t_we = in_acc && (in_data_i.mode == ModeTour);
      SNext: begin t_ra = CityW'(i_q - 1'b1); t_rb = i_q; end
      SRdT: begin t_ra = j_q; t_rb = CityW'(j_q + 1'b1); end
      SD0: d_ra = {c_a_q, c_c_q};
      SD1: d_ra = {c_b_q, c_d_q};
      SD2: d_ra = {c_a_q, c_b_q};
      SD3: d_ra = {c_c_q, c_d_q};
      SRev: begin
        t_we = 1'b1; t_wa = lo_q; t_wd = t_b_q; t_we2 = 1'b1;
      end
      // closing edge runs from p[0] to p[N-1]
      SLen: begin
        t_ra = (k_q == n1) ? '0 : k_q;
        t_rb = (k_q == n1) ? n1 : CityW'(k_q + 1'b1);
      end
      SLenW: d_ra = {t_a_q, t_b_q};
      SEmit, SEmitW: t_ra = k_q;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 7'd64; lim_q <= 8'd19;
    end else if (cfg_valid_i && cfg_ready_o) begin
      if (cfg_index_i == CfgCityCount) cnt_q <= cfg_data_i[6:0];
      else if (cfg_index_i == CfgPassLimit) lim_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= SIdle; pass_q <= '0; swap_q <= 1'b0; ob_full_q <= 1'b0;
      i_q <= '0; j_q <= '0; lo_q <= '0; hi_q <= '0; k_q <= '0;
      c_a_q <= '0; c_b_q <= '0; c_c_q <= '0; c_d_q <= '0;
      gain_q <= '0; cost_q <= '0; len_q <= '0; out_data_o <= '0;
    end else begin
      if (out_load) ob_full_q <= 1'b1;
      else if (out_ready_i) ob_full_q <= 1'b0;
      unique case (st_q)
        SIdle: if (in_acc && in_data_i.mode == ModeRun) begin
          pass_q <= '0; swap_q <= 1'b0; len_q <= '0; k_q <= '0;
          st_q <= (lim_q == 8'd0) ? SLen : SPass;
          i_q <= CityW'(1); j_q <= CityW'(2);
        end
        SPass: begin
          // i=1..N-3 have candidates; j ranges i+1..N-2
          if (pass_q == lim_q) st_q <= SLen;
          else begin
            swap_q <= 1'b0; i_q <= CityW'(1); j_q <= CityW'(2);
            st_q <= SNext;
          end
        end
        SNext: begin
          // tour reads for p[i-1],p[i] issued this cycle
          if (7'(i_q) + 7'd2 >= n_eff) begin
            pass_q <= pass_q + 1'b1;
            st_q <= (swap_q && pass_q + 1'b1 != lim_q) ? SPass : SLen;
            k_q <= '0; len_q <= '0;
          end else st_q <= SRdT;
        end
        SRdT: begin c_a_q <= t_a_q; c_b_q <= t_b_q; st_q <= SRdT2; end
        SRdT2: begin c_c_q <= t_a_q; c_d_q <= t_b_q; st_q <= SD0; end
        SD0: st_q <= SD1;
        SD1: begin gain_q <= {1'b0, d_q}; st_q <= SD2; end
        SD2: begin gain_q <= gain_q + {1'b0, d_q}; st_q <= SD3; end
        SD3: begin cost_q <= {1'b0, d_q}; st_q <= SCmp; end
        SCmp: begin
          if (better) begin
            swap_q <= 1'b1; lo_q <= i_q; hi_q <= j_q; st_q <= SRevRd;
          end else begin
            if (j_end) begin
              i_q <= CityW'(i_q + 1'b1); j_q <= CityW'(i_q + 2'd2);
            end else j_q <= CityW'(j_q + 1'b1);
            st_q <= SNext;
          end
        end
        SRevRd: st_q <= SRev;
        SRev: begin
          // swap written this cycle; stop once the inner pair would meet
          if (7'(lo_q) + 7'd2 >= 7'(hi_q)) begin
            if (j_end) begin
              i_q <= CityW'(i_q + 1'b1); j_q <= CityW'(i_q + 2'd2);
            end else j_q <= CityW'(j_q + 1'b1);
            st_q <= SNext;
          end else begin
            lo_q <= CityW'(lo_q + 1'b1); hi_q <= CityW'(hi_q - 1'b1);
            st_q <= SRevRd;
          end
        end
        SLen: st_q <= SLenW;
        SLenW: st_q <= SLenA;
        SLenA: begin
          len_q <= len_q + {{(LenW - DistW){1'b0}}, d_q};
          if (k_q == n1) begin
            k_q <= '0; st_q <= SEmit;
          end else begin
            k_q <= CityW'(k_q + 1'b1); st_q <= SLen;
          end
        end
        SEmit: st_q <= SEmitW;
        SEmitW: begin
          if (out_load) begin
            out_data_o.position <= k_q;
            out_data_o.city <= t_a_q;
            out_data_o.tour_length <= len_q;
            out_data_o.last <= (k_q == n1);
            if (k_q == n1) st_q <= SIdle;
            else begin k_q <= CityW'(k_q + 1'b1); st_q <= SEmit; end
          end
        end
        default: st_q <= SIdle;
      endcase
    end
  end

  property p_no_in_busy;
    @(posedge clk_i) disable iff (!rst_ni) (st_q != SIdle) |-> !in_ready_o;
  endproperty
  a_no_in_busy: assert property (p_no_in_busy) else $error("input taken during run");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> out_valid_o) else $error("result dropped");
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> $stable(out_data_o))
    else $error("result changed while stalled");
  a_pass_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pass_q <= lim_q || st_q == SIdle) else $error("pass count over limit");
endmodule
`default_nettype wire
